>>> hdl/srfr_pkg.sv
// Package with shared constants, types and the CRC step function of the frame receiver.
`default_nettype none
package srfr_pkg;

    localparam int WINDOW_DEPTH  = 5;
    localparam int PAYLOAD_BYTES = 8;

    localparam int SEQ_W     = 8;
    localparam int PAYLOAD_W = 64;
    localparam int CRC_W     = 16;
    localparam int IDX_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int OCC_W     = $clog2(WINDOW_DEPTH + 1);
    localparam int CRC_STEPS = 2 * PAYLOAD_BYTES;
    localparam int STEP_W    = (CRC_STEPS > 1) ? $clog2(CRC_STEPS) : 1;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h8408;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [SEQ_W-1:0] TOTAL_FRAMES_RESET = 8'd128;
    localparam logic [SEQ_W-1:0] EXPECTED_RESET     = 8'd1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_TOTAL_FRAMES = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CRC,
        ST_REPLY
    } t_state;

    typedef struct packed {
        logic             done;
        logic [CRC_W-1:0] crc;
    } t_crc_status;

    function automatic logic [CRC_W-1:0] crc_nibble(input logic [CRC_W-1:0] crc_in,
                                                    input logic [3:0] nib);
        logic [CRC_W-1:0] c;
        c = crc_in;
        for (int b = 0; b < 4; b++) begin
            if (c[0] ^ nib[b]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic is_done(input logic [SEQ_W-1:0] expected,
                                     input logic [SEQ_W-1:0] total);
        return (expected == '0) || (expected > total);
    endfunction

endpackage
`default_nettype wire

>>> hdl/srfr_crc_unit.sv
// Iterative CRC-16 unit that folds four payload bits into the remainder each cycle.
`default_nettype none
module srfr_crc_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [srfr_pkg::PAYLOAD_W-1:0]  i_payload,
    output srfr_pkg::t_crc_status                o_status
);

    logic [srfr_pkg::PAYLOAD_W-1:0] r_shift;
    logic [srfr_pkg::CRC_W-1:0]     r_crc;
    logic [srfr_pkg::STEP_W-1:0]    r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [7:0]                 w_byte;
    logic [3:0]                 w_nib;
    logic [srfr_pkg::CRC_W-1:0] w_fin;

    assign w_byte = r_shift[srfr_pkg::PAYLOAD_W-1 -: 8];
    assign w_nib  = r_cnt[0] ? w_byte[7:4] : w_byte[3:0];
    assign w_fin  = ~r_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == srfr_pkg::STEP_W'(srfr_pkg::CRC_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_payload;
            r_crc   <= srfr_pkg::CRC_INIT;
        end else if (r_busy) begin
            r_crc <= srfr_pkg::crc_nibble(r_crc, w_nib);
            if (r_cnt[0]) begin
                r_shift <= r_shift << 8;
            end
        end
    end

    assign o_status.done = r_done;
    assign o_status.crc  = {w_fin[7:0], w_fin[15:8]};

endmodule
`default_nettype wire

>>> hdl/selective_repeat_frame_receiver_top.sv
// Top level of the selective-repeat frame receiver with reorder window and CRC check.
//
// Frames enter on the input channel (i_in_valid, o_in_stall) and are stored in a
// five-slot reorder window. Once the window is full, each frame starts a search
// for the stored frame that carries the expected sequence number, one slot per
// cycle, followed by a CRC-16 over the payload computed four bits per cycle in
// a shared CRC unit (sixteen steps for eight bytes). A match gives one reply item
// on the output channel (o_out_valid, i_out_stall); no match gives no item.
// A frame that leaves the window short of full is only stored, and a frame that
// finds no match in a full window passes the accept step and the search.
// A frame that matches passes the accept step, the search, the CRC steps, a
// step to pick up the result and the reply step.
// The input is stalled while a frame is being worked on.
// The reply waits in an output register; if the receiver stalls and a new reply is
// ready, the block holds in its reply step until the register is free.
// Reset clears the window occupancy, sets the expected number to one and the
// total_frames register to 128. Window contents are not cleared.
// total_frames is written over the APB-style port at byte address 0.
`default_nettype none
module selective_repeat_frame_receiver_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [srfr_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [srfr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [srfr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [srfr_pkg::SEQ_W-1:0]        i_frame_seq,
    input  wire logic [srfr_pkg::PAYLOAD_W-1:0]    i_frame_payload,
    input  wire logic [srfr_pkg::CRC_W-1:0]        i_frame_crc,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_reply_nak,
    output logic      [srfr_pkg::SEQ_W-1:0]        o_reply_seq,
    output logic                                   o_deliver_valid,
    output logic      [srfr_pkg::PAYLOAD_W-1:0]    o_deliver_payload,
    output logic                                   o_all_done
);

    localparam int D = srfr_pkg::WINDOW_DEPTH;

    logic [srfr_pkg::SEQ_W-1:0]     r_slot_seq     [D];
    logic [srfr_pkg::PAYLOAD_W-1:0] r_slot_payload [D];
    logic [srfr_pkg::CRC_W-1:0]     r_slot_crc     [D];

    srfr_pkg::t_state            r_state, n_state;
    logic [srfr_pkg::OCC_W-1:0]  r_occ, n_occ;
    logic [srfr_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic [srfr_pkg::SEQ_W-1:0]  r_expected, n_expected;
    logic [srfr_pkg::SEQ_W-1:0]  r_total;

    logic                           r_out_valid, n_out_valid;
    logic                           r_nak, n_nak;
    logic [srfr_pkg::SEQ_W-1:0]     r_rseq, n_rseq;
    logic                           r_dvalid, n_dvalid;
    logic [srfr_pkg::PAYLOAD_W-1:0] r_dpayload, n_dpayload;
    logic                           r_all_done, n_all_done;

    logic w_accept, w_insert, w_compact, w_crc_start, w_cfg_wr, w_ok, w_out_free;
    srfr_pkg::t_crc_status w_crc;

    srfr_crc_unit u_crc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_crc_start),
        .i_payload (r_slot_payload[r_idx]),
        .o_status  (w_crc)
    );

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign prdata     = (paddr[2] == srfr_pkg::REG_TOTAL_FRAMES)
                        ? {{(srfr_pkg::APB_DATA_W - srfr_pkg::SEQ_W){1'b0}}, r_total}
                        : '0;

    assign o_in_stall = (r_state != srfr_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_ok       = (w_crc.crc == r_slot_crc[r_idx]);

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_idx       = r_idx;
        n_expected  = r_expected;
        n_out_valid = r_out_valid && i_out_stall;
        n_nak       = r_nak;
        n_rseq      = r_rseq;
        n_dvalid    = r_dvalid;
        n_dpayload  = r_dpayload;
        n_all_done  = r_all_done;
        w_insert    = 1'b0;
        w_compact   = 1'b0;
        w_crc_start = 1'b0;
        case (r_state)
            srfr_pkg::ST_IDLE: begin
                if (w_accept && !srfr_pkg::is_done(r_expected, r_total)) begin
                    n_idx = '0;
                    if (r_occ < srfr_pkg::OCC_W'(D)) begin
                        w_insert = 1'b1;
                        n_occ    = r_occ + 1'b1;
                        if (n_occ == srfr_pkg::OCC_W'(D)) begin
                            n_state = srfr_pkg::ST_SEARCH;
                        end
                    end else begin
                        n_state = srfr_pkg::ST_SEARCH;
                    end
                end
            end
            srfr_pkg::ST_SEARCH: begin
                if (r_slot_seq[r_idx] == r_expected) begin
                    w_crc_start = 1'b1;
                    n_state     = srfr_pkg::ST_CRC;
                end else if (r_idx == srfr_pkg::IDX_W'(D - 1)) begin
                    n_state = srfr_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            srfr_pkg::ST_CRC: begin
                if (w_crc.done) begin
                    n_state = srfr_pkg::ST_REPLY;
                end
            end
            srfr_pkg::ST_REPLY: begin
                if (w_out_free) begin
                    w_compact   = 1'b1;
                    n_occ       = r_occ - 1'b1;
                    n_expected  = r_expected + srfr_pkg::SEQ_W'(w_ok);
                    n_out_valid = 1'b1;
                    n_nak       = !w_ok;
                    n_rseq      = r_expected;
                    n_dvalid    = w_ok;
                    n_dpayload  = w_ok ? r_slot_payload[r_idx] : '0;
                    n_all_done  = srfr_pkg::is_done(n_expected, r_total);
                    n_state     = srfr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = srfr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srfr_pkg::ST_IDLE;
            r_occ       <= '0;
            r_idx       <= '0;
            r_expected  <= srfr_pkg::EXPECTED_RESET;
            r_total     <= srfr_pkg::TOTAL_FRAMES_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_idx       <= n_idx;
            r_expected  <= n_expected;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr && paddr[2] == srfr_pkg::REG_TOTAL_FRAMES) begin
                r_total <= pwdata[srfr_pkg::SEQ_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_nak      <= n_nak;
        r_rseq     <= n_rseq;
        r_dvalid   <= n_dvalid;
        r_dpayload <= n_dpayload;
        r_all_done <= n_all_done;
    end

    always_ff @(posedge i_clk) begin
        if (w_insert) begin
            r_slot_seq[r_occ[srfr_pkg::IDX_W-1:0]]     <= i_frame_seq;
            r_slot_payload[r_occ[srfr_pkg::IDX_W-1:0]] <= i_frame_payload;
            r_slot_crc[r_occ[srfr_pkg::IDX_W-1:0]]     <= i_frame_crc;
        end else if (w_compact) begin
            for (int i = 0; i < D - 1; i++) begin
                if (srfr_pkg::IDX_W'(i) >= r_idx) begin
                    r_slot_seq[i]     <= r_slot_seq[i + 1];
                    r_slot_payload[i] <= r_slot_payload[i + 1];
                    r_slot_crc[i]     <= r_slot_crc[i + 1];
                end
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_reply_nak       = r_nak;
    assign o_reply_seq       = r_rseq;
    assign o_deliver_valid   = r_dvalid;
    assign o_deliver_payload = r_dpayload;
    assign o_all_done        = r_all_done;

endmodule
`default_nettype wire

>>> hdl/srfr_checker.sv
// Port-level checker for the frame receiver, bound to the top level.
`default_nettype none
module srfr_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_in_stall,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_stall,
    input wire logic                              o_reply_nak,
    input wire logic [srfr_pkg::SEQ_W-1:0]        o_reply_seq,
    input wire logic                              o_deliver_valid,
    input wire logic [srfr_pkg::PAYLOAD_W-1:0]    o_deliver_payload
);

    a_ack_matches_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_deliver_valid == !o_reply_nak))
        else $error("Deliver flag disagrees with the reply kind.");

    a_nak_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_reply_nak) |-> (o_deliver_payload == '0))
        else $error("A NAK item carries a payload.");

    a_reply_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("A reply item appeared without a frame being worked on.");

    a_stalled_item_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_reply_seq) && $stable(o_reply_nak)))
        else $error("A stalled reply item changed.");

endmodule

bind selective_repeat_frame_receiver_top srfr_checker u_srfr_checker (.*);
`default_nettype wire
